/* rtl/dslq_pkg.sv */
// ----------------------------------------------------------------------------
// dslq_pkg
// Shared types and constants for the deadline slack load queue.
// ----------------------------------------------------------------------------
`default_nettype none
package dslq_pkg;
  localparam int QDEPTH = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;
  localparam logic [1:0] OP_COMPLETE_ALT = 2'd3;

  localparam logic [2:0] ST_QUEUED = 3'd0;
  localparam logic [2:0] ST_RESDONE = 3'd1;
  localparam logic [2:0] ST_REJECT = 3'd2;
  localparam logic [2:0] ST_DISP = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_COMPL = 3'd5;

  localparam logic [0:0] REG_MAX_PENDING = 1'd0;

  typedef struct packed {
    logic signed [48:0] lstart;
    logic [63:0] seq;
    logic [47:0] use_time;
    logic [15:0] tag;
  } entry_t;
endpackage
`default_nettype wire

/* rtl/deadline_slack_load_queue_top.sv */
// ----------------------------------------------------------------------------
// deadline_slack_load_queue_top
// Bounded least-slack load queue (minimum use_time - fetch_latency, ties to the
// earlier submission); entries in one sync RAM, min search by scan.
// Submit/complete: the input beat is registered in IDLE, the result in RES,
// and OUT holds it until out_ready; the next beat is taken back in IDLE.
// Dispatch: IDLE, then SCAN reads the entry RAM one entry per cycle
// (registered read port), then PICK, RES and OUT.
// One item in flight at a time. Synchronous active-low reset clears valid
// bits, counters and occupancy; the entry RAM is not cleared.
`default_nettype none
module deadline_slack_load_queue_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_job_tag,
  input  wire logic [47:0] in_use_time,
  input  wire logic [31:0] in_fetch_latency,
  input  wire logic [39:0] in_payload_bytes,
  input  wire logic        in_resident,
  input  wire logic [47:0] in_now,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [15:0]      out_job_tag,
  output logic [47:0]      out_use_time,
  output logic [4:0]       out_pending_count,
  output logic             out_late,
  output logic [63:0]      out_submission_total,
  output logic [63:0]      out_resident_total,
  output logic [63:0]      out_completion_total,
  output logic [63:0]      out_miss_total,
  output logic [63:0]      out_bytes_total,
  output logic [4:0]       out_high_water,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_RES = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  dslq_pkg::entry_t mem [dslq_pkg::QDEPTH];
  dslq_pkg::entry_t rd_q;
  logic [dslq_pkg::IDX_W-1:0] rd_addr;
  logic mem_we;
  logic [dslq_pkg::IDX_W-1:0] wr_addr;
  dslq_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  logic [2:0] state_r;
  logic [dslq_pkg::QDEPTH-1:0] valid_r;
  logic [4:0] maxp_r, occ_r, peak_r;
  logic [63:0] arr_r, sub_r, res_r, cmp_r, miss_r, byt_r;
  logic [1:0] op_r;
  logic [15:0] tag_r;
  logic [47:0] use_r, now_r;
  logic [31:0] lat_r;
  logic [39:0] byt_in_r;
  logic resid_r;
  logic [dslq_pkg::IDX_W:0] scan_r;
  logic [dslq_pkg::IDX_W-1:0] chk_r, best_r;
  logic chk_v_r, have_r;
  logic signed [48:0] best_ls_r;
  logic [63:0] best_seq_r;
  logic [15:0] best_tag_r;
  logic [47:0] best_use_r;
  logic [dslq_pkg::IDX_W-1:0] free_idx;
  logic free_any;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = dslq_pkg::QDEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = i[dslq_pkg::IDX_W-1:0];
        free_any = 1'b1;
      end
    end
  end

  logic [4:0] limit;
  assign limit = (maxp_r < 5'(dslq_pkg::QDEPTH)) ? maxp_r : 5'(dslq_pkg::QDEPTH);
  logic late_c;
  assign late_c = now_r > use_r;

  assign in_ready = (state_r == S_IDLE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == dslq_pkg::REG_MAX_PENDING) ? {27'd0, maxp_r} : 32'd0;
  assign rd_addr = scan_r[dslq_pkg::IDX_W-1:0];
  assign wr_addr = free_idx;
  assign wr_data = '{lstart: $signed({1'b0, use_r}) - $signed({17'd0, lat_r}),
                     seq: arr_r, use_time: use_r, tag: tag_r};
  assign mem_we = (state_r == S_RES) && (op_r == dslq_pkg::OP_SUBMIT) && !resid_r
                  && (occ_r < limit) && free_any;

  logic better;
  assign better = !have_r || (rd_q.lstart < best_ls_r) ||
                  (rd_q.lstart == best_ls_r && rd_q.seq < best_seq_r);

  logic res_is_disp;
  logic res_has_late;
  assign res_is_disp = (op_r == dslq_pkg::OP_DISPATCH);
  assign res_has_late = (op_r == dslq_pkg::OP_SUBMIT) ? resid_r : !res_is_disp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; maxp_r <= 5'd16; occ_r <= '0; peak_r <= '0;
      arr_r <= '0; sub_r <= '0; res_r <= '0; cmp_r <= '0; miss_r <= '0; byt_r <= '0;
      out_valid <= 1'b0; chk_v_r <= 1'b0; have_r <= 1'b0; scan_r <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == dslq_pkg::REG_MAX_PENDING)
        maxp_r <= cfg_pwdata[4:0];
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_operation; tag_r <= in_job_tag; use_r <= in_use_time;
            lat_r <= in_fetch_latency; byt_in_r <= in_payload_bytes;
            resid_r <= in_resident; now_r <= in_now;
            scan_r <= '0; have_r <= 1'b0; chk_v_r <= 1'b0;
            state_r <= (in_operation == dslq_pkg::OP_DISPATCH) ? S_SCAN : S_RES;
          end
        end
        S_SCAN: begin
          chk_v_r <= valid_r[rd_addr];
          chk_r <= rd_addr;
          if (chk_v_r && better) begin
            have_r <= 1'b1; best_r <= chk_r; best_ls_r <= rd_q.lstart;
            best_seq_r <= rd_q.seq; best_tag_r <= rd_q.tag; best_use_r <= rd_q.use_time;
          end
          if (scan_r == 5'(dslq_pkg::QDEPTH)) state_r <= S_PICK;
          else scan_r <= scan_r + 5'd1;
        end
        S_PICK: begin
          state_r <= S_RES;
        end
        S_RES: begin
          out_late <= res_has_late && late_c;
          out_job_tag <= (res_is_disp && have_r) ? best_tag_r : tag_r;
          out_use_time <= res_is_disp ? (have_r ? best_use_r : 48'd0) : use_r;
          if (op_r == dslq_pkg::OP_SUBMIT) begin
            if (resid_r) begin
              sub_r <= sub_r + 64'd1; res_r <= res_r + 64'd1; cmp_r <= cmp_r + 64'd1;
              byt_r <= byt_r + {24'd0, byt_in_r};
              if (late_c) miss_r <= miss_r + 64'd1;
              out_status <= dslq_pkg::ST_RESDONE;
            end else if (mem_we) begin
              valid_r[free_idx] <= 1'b1;
              arr_r <= arr_r + 64'd1; occ_r <= occ_r + 5'd1;
              sub_r <= sub_r + 64'd1; byt_r <= byt_r + {24'd0, byt_in_r};
              if (occ_r + 5'd1 > peak_r) peak_r <= occ_r + 5'd1;
              out_status <= dslq_pkg::ST_QUEUED;
            end else begin
              out_status <= dslq_pkg::ST_REJECT;
            end
          end else if (res_is_disp) begin
            if (have_r) begin
              valid_r[best_r] <= 1'b0;
              if (occ_r != 5'd0) occ_r <= occ_r - 5'd1;
              out_status <= dslq_pkg::ST_DISP;
            end else begin
              out_status <= dslq_pkg::ST_EMPTY;
            end
          end else begin
            cmp_r <= cmp_r + 64'd1;
            if (late_c) miss_r <= miss_r + 64'd1;
            out_status <= dslq_pkg::ST_COMPL;
          end
          out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_pending_count = occ_r;
  assign out_high_water = peak_r;
  assign out_submission_total = sub_r;
  assign out_resident_total = res_r;
  assign out_completion_total = cmp_r;
  assign out_miss_total = miss_r;
  assign out_bytes_total = byt_r;
endmodule
`default_nettype wire

/* rtl/dslq_checker.sv */
// ----------------------------------------------------------------------------
// dslq_props
// Port-level checks for the deadline slack load queue.
// ----------------------------------------------------------------------------
`default_nettype none
module dslq_props (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] out_status,
  input wire logic [4:0] out_pending_count,
  input wire logic [4:0] out_high_water
);
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pending_count <= 5'(dslq_pkg::QDEPTH)) else $error("occupancy overflow");
  a_hw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dslq_pkg::ST_QUEUED |-> out_high_water >= out_pending_count)
    else $error("high water below occupancy");
endmodule

bind deadline_slack_load_queue_top dslq_props u_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_pending_count(out_pending_count), .out_high_water(out_high_water)
);
`default_nettype wire
